### design/arc_pkg.sv
// ----------------------------------------------------------------------------
// arc_pkg: shared types and constants of the arcball drag rotation block
// Holds the sequencer opcodes of the shared divide / square-root unit and
// fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none
package arc_pkg;

  localparam logic signed [15:0] Q_ONE = 16'sd16384;

  // register indexes
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;

  // operation of the shared iterative unit
  typedef enum logic [0:0] {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } unit_op_t;

  // request from the sequencer to the shared unit
  typedef struct packed {
    logic        start;
    unit_op_t    op;
    logic [63:0] num;
    logic [63:0] den;
  } unit_req_t;

  // answer of the shared unit
  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [63:0] rem;
  } unit_rsp_t;

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    if (v < -48'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage
`default_nettype wire

### design/arcball_drag_rotation.sv
// ----------------------------------------------------------------------------
// arcball_drag_rotation: arcball drag quaternion from pointer events
// A press stores the drag start; a motion maps start and current point on
// the sphere and keeps (dot, cross) as the drag quaternion. Every event
// returns the kept quaternion.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)            | tuser
//  in_     | in  | x_pos[15:0], y_pos[31:16]            | op
//  out_    | out | quat_w, quat_x, quat_y, quat_z (64b)  | -
//  cfg_    | in  | index (2b), data (16b)               | -
//
//  A motion maps two points, each with one square root and, inside the
//  ball, three divides, outside two, on the one shared unit. Reset is
//  synchronous and leaves the identity quaternion. in_tready is low while
//  an event is in work or its result waits on out_tready.
// ----------------------------------------------------------------------------
`default_nettype none
module arcball_drag_rotation (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // x_pos, y_pos
  input  wire  [0:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,  // quat_w, quat_x, quat_y, quat_z
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_D2, S_SQ, S_DX, S_DY, S_DZ, S_VEC, S_QUAT, S_OUT
  } state_t;

  state_t state_r;
  logic signed [15:0] cx_r, cy_r;
  logic [14:0] rad_r;
  logic signed [15:0] sx_r, sy_r, px_r, py_r;
  logic signed [15:0] rot_r [4];
  logic signed [15:0] a_r [3];
  logic signed [15:0] b_r [3];
  logic pt_r;       // 0: start point, 1: current point
  logic outside_r;
  logic signed [16:0] dx_r, dy_r;
  logic [33:0] r2_r;
  logic [63:0] m_r;
  logic signed [15:0] vx_r, vy_r;
  logic signed [15:0] vz_hold;
  logic [1:0] qi_r;

  arc_pkg::unit_req_t req;
  arc_pkg::unit_rsp_t rsp;

  arc_divsqrt u_unit (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  logic [14:0] r_eff;
  assign r_eff = (rad_r == 15'd0) ? 15'd1 : rad_r;

  // |d| * scale numerators and rounded-divide numerator 2a+den
  logic [16:0] adx, ady;
  assign adx = dx_r[16] ? 17'(-dx_r) : 17'(dx_r);
  assign ady = dy_r[16] ? 17'(-dy_r) : 17'(dy_r);
  logic [63:0] den_xy;
  assign den_xy = outside_r ? m_r : {49'd0, r_eff};
  function automatic logic [63:0] scaled(input logic [16:0] a, input logic o);
    return o ? ({47'd0, a} << 22) : ({47'd0, a} << 14);
  endfunction

  // squared distance from the centre
  logic [33:0] d2_sum;
  assign d2_sum = ({17'd0, adx} * {17'd0, adx}) + ({17'd0, ady} * {17'd0, ady});

  // start the shared unit on entry to each divide or root
  logic unit_go;
  assign unit_go = (state_r == S_D2) ||
                   (rsp.done && (state_r == S_SQ || state_r == S_DX));

  // signed quotient with saturation
  function automatic logic signed [15:0] sgnq(input logic [63:0] q,
                                              input logic neg);
    logic signed [47:0] v;
    v = (q > 64'd40000) ? 48'sd40000 : $signed({1'b0, q[46:0]});
    return arc_pkg::sat16(neg ? -v : v);
  endfunction

  // quaternion products, one component a cycle
  logic signed [31:0] p0, p1, p2;
  logic signed [33:0] qsum;
  logic signed [33:0] qt;
  always_comb begin
    p0 = '0; p1 = '0; p2 = '0;
    unique case (qi_r)
      2'd0: begin
        p0 = a_r[0] * b_r[0]; p1 = a_r[1] * b_r[1]; p2 = a_r[2] * b_r[2];
      end
      2'd1: begin p0 = a_r[1] * b_r[2]; p1 = -(a_r[2] * b_r[1]); end
      2'd2: begin p0 = a_r[2] * b_r[0]; p1 = -(a_r[0] * b_r[2]); end
      default: begin p0 = a_r[0] * b_r[1]; p1 = -(a_r[1] * b_r[0]); end
    endcase
    qsum = 34'(p0) + 34'(p1) + 34'(p2);
    qt   = (qsum + 34'sd8192) >>> 14;
  end

  // sqrt rounding: bump when n > s*s + s, i.e. remainder > s
  logic [63:0] sq_round;
  assign sq_round = (rsp.rem > rsp.quo) ? rsp.quo + 64'd1 : rsp.quo;

  always_ff @(posedge clk) begin
    req.start <= rst_n && unit_go;
    if (!rst_n) begin
      state_r <= S_IDLE;
      cx_r <= '0; cy_r <= '0; rad_r <= 15'd256;
      sx_r <= '0; sy_r <= '0;
      rot_r[0] <= arc_pkg::Q_ONE; rot_r[1] <= '0; rot_r[2] <= '0; rot_r[3] <= '0;
    end else begin
      // configuration is to be written while idle; the block does not enforce it
      if (cfg_valid) begin
        unique case (cfg_index)
          arc_pkg::REG_CENTER_X: cx_r <= cfg_data;
          arc_pkg::REG_CENTER_Y: cy_r <= cfg_data;
          arc_pkg::REG_RADIUS:   rad_r <= cfg_data[14:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          px_r <= in_tdata[15:0];
          py_r <= in_tdata[31:16];
          if (in_tuser[0] == 1'b0) begin
            sx_r <= in_tdata[15:0];
            sy_r <= in_tdata[31:16];
            state_r <= S_OUT;
          end else begin
            pt_r <= 1'b0;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          dx_r <= pt_r ? (17'(px_r) - 17'(cx_r)) : (17'(sx_r) - 17'(cx_r));
          dy_r <= pt_r ? (17'(py_r) - 17'(cy_r)) : (17'(sy_r) - 17'(cy_r));
          r2_r <= {19'd0, r_eff} * {19'd0, r_eff};
          state_r <= S_D2;
        end
        S_D2: begin
          outside_r <= d2_sum > r2_r;
          if (d2_sum > r2_r) begin
            req.op  <= arc_pkg::OP_SQRT;
            req.num <= {14'd0, d2_sum, 16'd0};
          end else begin
            req.op  <= arc_pkg::OP_DIV;
            req.num <= {2'd0, r2_r - d2_sum, 28'd0};
            req.den <= {30'd0, r2_r};
          end
          state_r <= S_SQ;
        end
        S_SQ: begin
          // inside: divide done, now root; outside: root done, keep m
          if (rsp.done) begin
            if (outside_r || req.op == arc_pkg::OP_SQRT) begin
              if (outside_r) m_r <= rsp.quo;
              else vz_hold <= arc_pkg::sat16(48'(sq_round));
              req.op    <= arc_pkg::OP_DIV;
              req.num   <= (scaled(adx, outside_r) << 1) +
                           (outside_r ? rsp.quo : {49'd0, r_eff});
              req.den   <= (outside_r ? rsp.quo : {49'd0, r_eff}) << 1;
              state_r   <= S_DX;
            end else begin
              req.op    <= arc_pkg::OP_SQRT;
              req.num   <= rsp.quo;
            end
          end
        end
        S_DX: if (rsp.done) begin
          vx_r <= sgnq(rsp.quo, dx_r[16]);
          req.op    <= arc_pkg::OP_DIV;
          req.num   <= (scaled(ady, outside_r) << 1) + den_xy;
          req.den   <= den_xy << 1;
          state_r   <= S_DY;
        end
        S_DY: if (rsp.done) begin
          vy_r <= sgnq(rsp.quo, dy_r[16]);
          state_r <= S_VEC;
        end
        S_VEC: begin
          if (pt_r) begin
            b_r[0] <= vx_r; b_r[1] <= vy_r;
            b_r[2] <= outside_r ? 16'sd0 : vz_hold;
            qi_r <= 2'd0;
            state_r <= S_QUAT;
          end else begin
            a_r[0] <= vx_r; a_r[1] <= vy_r;
            a_r[2] <= outside_r ? 16'sd0 : vz_hold;
            pt_r <= 1'b1;
            state_r <= S_PREP;
          end
        end
        S_QUAT: begin
          rot_r[qi_r] <= arc_pkg::sat16(48'(qt));
          qi_r <= qi_r + 2'd1;
          if (qi_r == 2'd3) state_r <= S_OUT;
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {rot_r[3], rot_r[2], rot_r[1], rot_r[0]};
  assign cfg_ready  = 1'b1;

endmodule
`default_nettype wire

### design/arc_divsqrt.sv
// ----------------------------------------------------------------------------
// arc_divsqrt: shared iterative unit
// Restoring divide of 64-bit numbers, one quotient bit a cycle, or integer
// square root, one result bit a cycle. Quotient / root in quo, remainder rem.
// ----------------------------------------------------------------------------
`default_nettype none
module arc_divsqrt (
  input  wire              clk,
  input  wire              rst_n,
  input  wire arc_pkg::unit_req_t req,
  output arc_pkg::unit_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  arc_pkg::unit_op_t op_r, op_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] n_r, n_nxt;
  logic [63:0] d_r, d_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] q_r, q_nxt;

  logic [64:0] trial;
  logic [64:0] sqt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    trial    = '0;
    sqt      = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      n_nxt    = req.num;
      d_nxt    = req.den;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = (req.op == arc_pkg::OP_SQRT) ? 6'd31 : 6'd63;
    end else if (busy_r) begin
      if (op_r == arc_pkg::OP_DIV) begin
        // shift in one numerator bit, subtract when it fits
        trial = {rem_r[63:0], n_r[63]};
        n_nxt = {n_r[62:0], 1'b0};
        if (trial >= {1'b0, d_r}) begin
          rem_nxt = trial - {1'b0, d_r};
          q_nxt   = {q_r[62:0], 1'b1};
        end else begin
          rem_nxt = trial;
          q_nxt   = {q_r[62:0], 1'b0};
        end
      end else begin
        // take two radicand bits, try root bit one
        trial = {rem_r[62:0], n_r[63:62]};
        n_nxt = {n_r[61:0], 2'b00};
        sqt   = {q_r[62:0], 2'b01};
        if (trial >= sqt) begin
          rem_nxt = trial - sqt;
          q_nxt   = {q_r[62:0], 1'b1};
        end else begin
          rem_nxt = trial;
          q_nxt   = {q_r[62:0], 1'b0};
        end
      end
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
  assign rsp.rem  = rem_r[63:0];

endmodule
`default_nettype wire

### bench/tb_arcball_drag_rotation.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arcball_drag_rotation: self-checking bench of the arcball drag block
// Drives press and motion events with random idling on both streams and
// compares every returned quaternion with a behavioural fixed-point predictor
// of the sphere mapping and the dot / cross product.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_arcball_drag_rotation;

  localparam logic       OP_PRESS  = 1'b0;
  localparam logic       OP_MOTION = 1'b1;
  localparam logic [1:0] REG_NONE  = 2'd3;
  localparam int         LIMIT     = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  arcball_drag_rotation dut (.*);

  always #10 clk = ~clk;

  // predictor state
  logic signed [15:0] cen_x, cen_y;
  logic [14:0]        radius;
  logic signed [15:0] drag_x, drag_y;
  logic signed [15:0] kept_q [4];

  logic [63:0] quat_q[$];
  int          errors = 0;
  bit          quiet = 1'b0;   // no idling stretch
  longint      cycles = 0;

  typedef struct {
    logic               op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    bit                 known;
    logic [63:0]        q;
  } event_row_t;

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res = 0, bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else res >>= 1;
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned a, q;
    a = num < 0 ? longint'(-num) : num;
    q = (2 * a + den) / (2 * den);
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic signed [15:0] round_q14(longint p);
    longint t;
    t = p + 8192;
    return 16'(clip16(t >>> 14));
  endfunction

  // map a point onto the unit sphere, Q1.14
  task automatic sphere_point(input longint px, py, output longint v[3]);
    longint unsigned r, r2, d2, m, n, s;
    longint dx, dy;
    r = radius == 0 ? 1 : radius;
    dx = px - cen_x;
    dy = py - cen_y;
    d2 = dx * dx + dy * dy;
    r2 = r * r;
    if (d2 > r2) begin
      m = isqrt(d2 << 16);
      v[0] = clip16(round_div(dx * 4194304, m));
      v[1] = clip16(round_div(dy * 4194304, m));
      v[2] = 0;
    end else begin
      n = ((r2 - d2) << 28) / r2;
      s = isqrt(n);
      if (n > s * s + s) s++;
      v[0] = clip16(round_div(dx * 16384, r));
      v[1] = clip16(round_div(dy * 16384, r));
      v[2] = clip16(s);
    end
  endtask

  function automatic logic [63:0] pack_quat();
    return {kept_q[3], kept_q[2], kept_q[1], kept_q[0]};
  endfunction

  task automatic predict_rotation(input logic op, input logic signed [15:0] x, y);
    longint a[3], b[3];
    if (op == OP_PRESS) begin
      drag_x = x;
      drag_y = y;
    end else begin
      sphere_point(drag_x, drag_y, a);
      sphere_point(x, y, b);
      kept_q[0] = round_q14(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
      kept_q[1] = round_q14(a[1] * b[2] - a[2] * b[1]);
      kept_q[2] = round_q14(a[2] * b[0] - a[0] * b[2]);
      kept_q[3] = round_q14(a[0] * b[1] - a[1] * b[0]);
    end
    quat_q.push_back(pack_quat());
  endtask

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // check each result transaction
  always @(posedge clk) begin
    logic [63:0] exp_q;
    if (rst_n && out_tvalid && out_tready) begin
      if (quat_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        exp_q = quat_q.pop_front();
        for (int k = 0; k < 4; k++)
          if (out_tdata[16*k +: 16] !== exp_q[16*k +: 16]) begin
            $display("%0t: quat field %0d expected %0d got %0d", $time, k,
                     $signed(exp_q[16*k +: 16]), $signed(out_tdata[16*k +: 16]));
            errors++;
          end
      end
    end
  end

  // receiver stall
  always @(negedge clk)
    out_tready <= quiet || ($urandom_range(99) >= 21);

  // hold valid across back-to-back transactions, drop it only while idling
  task automatic send_event(input logic op, input logic signed [15:0] x, y);
    while (!quiet && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_rotation(op, x, y);
    @(negedge clk);
  endtask

  task automatic drain();
    int guard = 0;
    in_tvalid <= 1'b0;
    while (quat_q.size() != 0) @(posedge clk);
    while (guard < 600) begin
      @(posedge clk);
      guard++;
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      arc_pkg::REG_CENTER_X: cen_x = val;
      arc_pkg::REG_CENTER_Y: cen_y = val;
      arc_pkg::REG_RADIUS:   radius = val[14:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_ball(input logic [15:0] cx, cy, r);
    write_reg(arc_pkg::REG_CENTER_X, cx);
    write_reg(arc_pkg::REG_CENTER_Y, cy);
    write_reg(arc_pkg::REG_RADIUS, r);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] near_coord(logic signed [15:0] c, int span);
    return 16'(clip16(longint'(c) + $signed($urandom_range(2 * span)) - span));
  endfunction

  initial begin
    event_row_t rows[$];
    logic [63:0] exp_q;
    logic signed [15:0] px, py;
    int span;

    cen_x = 0; cen_y = 0; radius = 256;
    drag_x = 0; drag_y = 0;
    kept_q = '{16384, 0, 0, 0};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table: identity rows can be read off directly
    rows = '{
      '{OP_PRESS,  16'sd100,    16'sd50,     1'b1, 64'h0000_0000_0000_4000},
      '{OP_MOTION, 16'sd0,      16'sd0,      1'b0, '0},
      '{OP_MOTION, 16'sd0,      16'sd0,      1'b0, '0},
      '{OP_PRESS,  16'sd0,      16'sd0,      1'b0, '0},
      '{OP_MOTION, 16'sd0,      16'sd0,      1'b1, 64'h0000_0000_0000_4000},
      '{OP_MOTION, 16'sd256,    16'sd0,      1'b0, '0},
      '{OP_MOTION, -16'sd256,   16'sd0,      1'b0, '0},
      '{OP_MOTION, 16'sd0,      16'sd256,    1'b0, '0},
      '{OP_MOTION, 16'sd181,    -16'sd181,   1'b0, '0},
      '{OP_PRESS,  16'sh7fff,   16'sh7fff,   1'b0, '0},
      '{OP_MOTION, -16'sh8000,  -16'sh8000,  1'b0, '0},
      '{OP_MOTION, 16'sh7fff,   -16'sh8000,  1'b0, '0},
      '{OP_PRESS,  -16'sh8000,  16'sh7fff,   1'b0, '0},
      '{OP_MOTION, 16'sd300,    16'sd10,     1'b0, '0},
      '{OP_MOTION, -16'sd1,     16'sh5555,   1'b0, '0},
      '{OP_PRESS,  16'shaaaa,   16'sd257,    1'b0, '0},
      '{OP_MOTION, 16'sd90,     -16'sd200,   1'b0, '0}
    };
    foreach (rows[i]) begin
      send_event(rows[i].op, rows[i].x, rows[i].y);
      if (rows[i].known) begin
        exp_q = pack_quat();
        if (exp_q !== rows[i].q) begin
          $display("%0t: table row %0d expected %h predicted %h", $time, i,
                   rows[i].q, exp_q);
          errors++;
        end
      end
    end
    drain();

    // random phases over several ball settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_ball(16'sh7fff, 16'sh8000, 16'd32767);
        1: set_ball(16'sh8000, 16'sh7fff, 16'd0);
        2: set_ball(16'd0, 16'd0, 16'd1);
        3: begin
          write_reg(REG_NONE, 16'hffff);   // unmapped index, ignored
          set_ball(16'(100), 16'(-50), 16'd300);
        end
        default: set_ball(16'($urandom), 16'($urandom), 16'($urandom_range(32767)));
      endcase
      quiet = (ph == 5);
      span = 2 * int'(radius) + 2;
      for (int n = 0; n < 50; n++) begin
        // drags mostly around the ball, some anywhere
        if ($urandom_range(9) < 2) begin
          px = 16'($urandom); py = 16'($urandom);
        end else begin
          px = near_coord(cen_x, span); py = near_coord(cen_y, span);
        end
        send_event(($urandom_range(3) == 0) ? OP_PRESS : OP_MOTION, px, py);
      end
      drain();
    end

    if (errors == 0 && quat_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

### files.f
design/arc_pkg.sv
design/arc_divsqrt.sv
design/arcball_drag_rotation.sv
bench/tb_arcball_drag_rotation.sv
